FILE: src/bfsd_pkg.sv
package bfsd_pkg;

    localparam int MAX_FIXED_BYTES_DEF = 8;

    localparam int LEN_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 64;
    localparam int SHIFT_W = 5;

    // vbe group positions
    localparam logic [SHIFT_W-1:0] GROUP_STEP = 5'd7;
    localparam logic [SHIFT_W-1:0] GROUP_LAST = 5'd28;

    typedef enum logic [1:0] {
        KIND_FIX_U = 2'd0,
        KIND_FIX_S = 2'd1,
        KIND_VBE_U = 2'd2,
        KIND_VBE_S = 2'd3
    } kind_t;

    typedef struct packed {
        logic                in_field;
        kind_t               kind;
        logic [LEN_W-1:0]    bytes_left;
        logic [VALUE_W-1:0]  acc;
        logic [SHIFT_W-1:0]  group_shift;
    } dec_state_t;

    typedef struct packed {
        logic               emit;
        logic [VALUE_W-1:0] value;
        logic               overlong;
    } dec_result_t;

endpackage

FILE: src/binary_field_stream_decoder.sv
// channel | port group        | content (low bit up)
// --------+-------------------+-------------------------------------------
// input   | s_tvalid/tready   | tuser: op[1:0]; tdata: field_length[3:0],
//         |                   |   data_byte[11:4], zero pad [15:12]
// result  | m_tvalid/tready   | tdata: value[63:0]; tuser: overlong[0]
//
// Each byte is taken into an input register, decoded combinationally and the
// finished field lands in the result register: one byte per cycle unless stalled.
// m_tvalid rises when the field's last byte leaves the input register.
// aresetn (synchronous, active low) clears both stage valids and the field state.
// A held result stalls decode; the input register keeps taking bytes until full.
module binary_field_stream_decoder #(
    parameter int MAX_FIXED_BYTES = bfsd_pkg::MAX_FIXED_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // field_length[3:0], data_byte[11:4], pad
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value[63:0]
    output logic [0:0]  m_tuser    // overlong[0]
);

    logic                           in_vld_reg;
    logic [1:0]                     in_op_reg;
    logic [bfsd_pkg::LEN_W-1:0]     in_len_reg;
    logic [bfsd_pkg::BYTE_W-1:0]    in_byte_reg;

    bfsd_pkg::dec_state_t           st_reg;
    bfsd_pkg::dec_state_t           st_next;
    bfsd_pkg::dec_result_t          res;

    logic                           out_vld_reg;
    logic [63:0]                    out_val_reg;
    logic                           out_ovl_reg;

    logic                           advance;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    bfsd_core #(
        .MAX_FIXED_BYTES(MAX_FIXED_BYTES)
    ) u_core (
        .state_cur    (st_reg),
        .op           (in_op_reg),
        .field_length (in_len_reg),
        .data_byte    (in_byte_reg),
        .state_nxt    (st_next),
        .result       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_len_reg  <= s_tdata[3:0];
            in_byte_reg <= s_tdata[11:4];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && res.emit) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
        if (advance && res.emit) begin
            out_val_reg <= res.value;
            out_ovl_reg <= res.overlong;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_val_reg;
    assign m_tuser[0] = out_ovl_reg;

    // an overlong field is always a vbe one: 32-bit value, zero or sign extended
    a_ovl_width: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_ovl_reg |-> (out_val_reg[63:32] == 32'd0)
                                    || (out_val_reg[63:32] == 32'hFFFF_FFFF))
        else $error("overlong result with a 64-bit value");

    a_fix_count: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.in_field && !st_reg.kind[1] |->
            st_reg.bytes_left != '0
            && st_reg.bytes_left < bfsd_pkg::LEN_W'(MAX_FIXED_BYTES))
        else $error("fixed field byte count out of range");

    a_vbe_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.in_field && st_reg.kind[1] |->
            st_reg.group_shift == 5'd0 || st_reg.group_shift == 5'd7
            || st_reg.group_shift == 5'd14 || st_reg.group_shift == 5'd21
            || st_reg.group_shift == 5'd28)
        else $error("vbe group shift off the 7-bit grid");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(in_byte_reg))
        else $error("stalled input item lost");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg))
        else $error("field state changed without a decoded item");

endmodule

FILE: src/bfsd_core.sv
module bfsd_core #(
    parameter int MAX_FIXED_BYTES = bfsd_pkg::MAX_FIXED_BYTES_DEF
) (
    input  bfsd_pkg::dec_state_t          state_cur,
    input  logic [1:0]                    op,
    input  logic [bfsd_pkg::LEN_W-1:0]    field_length,
    input  logic [bfsd_pkg::BYTE_W-1:0]   data_byte,
    output bfsd_pkg::dec_state_t          state_nxt,
    output bfsd_pkg::dec_result_t         result
);

    localparam logic [bfsd_pkg::LEN_W-1:0] MAX_LEN = bfsd_pkg::LEN_W'(MAX_FIXED_BYTES);

    bfsd_pkg::kind_t                    kind;
    logic [bfsd_pkg::LEN_W-1:0]         len_c;
    logic [bfsd_pkg::VALUE_W-1:0]       first_val;
    logic [31:0]                        acc_base;
    logic [bfsd_pkg::SHIFT_W-1:0]       gs;
    logic [31:0]                        grp7;
    logic [31:0]                        grp6;
    logic [31:0]                        acc32;
    logic [31:0]                        mag;

    always_comb begin
        kind     = state_cur.in_field ? state_cur.kind : bfsd_pkg::kind_t'(op);
        acc_base = state_cur.in_field ? state_cur.acc[31:0] : 32'd0;
        gs       = state_cur.in_field ? state_cur.group_shift : '0;
        grp7     = {25'd0, data_byte[6:0]} << gs;
        grp6     = {26'd0, data_byte[5:0]} << gs;
        acc32    = acc_base | grp7;
        mag      = acc_base | grp6;
        if (data_byte[6]) begin
            mag = 32'd0 - mag;
        end

        len_c = field_length;
        if (len_c == '0) begin
            len_c = bfsd_pkg::LEN_W'(1);
        end
        if (len_c > MAX_LEN) begin
            len_c = MAX_LEN;
        end

        first_val = {56'd0, data_byte};
        if (op[0] && data_byte[7]) begin
            first_val[63:8] = '1;
        end

        state_nxt       = state_cur;
        result.emit     = 1'b0;
        result.value    = state_cur.acc;
        result.overlong = 1'b0;

        if (!state_cur.in_field && !op[1]) begin
            // first byte of a fixed field
            state_nxt.kind = bfsd_pkg::kind_t'(op);
            state_nxt.acc  = first_val;
            if (len_c == bfsd_pkg::LEN_W'(1)) begin
                result.emit  = 1'b1;
                result.value = first_val;
            end else begin
                state_nxt.in_field   = 1'b1;
                state_nxt.bytes_left = len_c - bfsd_pkg::LEN_W'(1);
            end
        end else if (state_cur.in_field && !state_cur.kind[1]) begin
            state_nxt.acc        = {state_cur.acc[55:0], data_byte};
            state_nxt.bytes_left = state_cur.bytes_left - bfsd_pkg::LEN_W'(1);
            if (state_cur.bytes_left == bfsd_pkg::LEN_W'(1)) begin
                state_nxt.in_field = 1'b0;
                result.emit        = 1'b1;
                result.value       = {state_cur.acc[55:0], data_byte};
            end
        end else begin
            state_nxt.kind        = kind;
            state_nxt.in_field    = 1'b1;
            state_nxt.group_shift = gs;
            state_nxt.acc         = {32'd0, acc_base};
            if (kind == bfsd_pkg::KIND_VBE_U) begin
                state_nxt.acc = {32'd0, acc32};
                if (!data_byte[7] || gs >= bfsd_pkg::GROUP_LAST) begin
                    state_nxt.in_field = 1'b0;
                    result.emit        = 1'b1;
                    result.value       = {32'd0, acc32};
                    result.overlong    = data_byte[7];
                end else begin
                    state_nxt.group_shift = gs + bfsd_pkg::GROUP_STEP;
                end
            end else begin
                if (data_byte[7] && gs < bfsd_pkg::GROUP_LAST) begin
                    state_nxt.acc         = {32'd0, acc32};
                    state_nxt.group_shift = gs + bfsd_pkg::GROUP_STEP;
                end else begin
                    // last byte: bit 6 is a sign-magnitude sign
                    state_nxt.in_field = 1'b0;
                    result.emit        = 1'b1;
                    result.value       = {{32{mag[31]}}, mag};
                    result.overlong    = data_byte[7];
                end
            end
        end
    end

endmodule
